// ===== rtl/core/psp_pkg.sv =====
// psp_pkg: shared types, constants and tables of the piecewise sigmoid projection core
// no dependencies; imported by psp_mul and piecewise_sigmoid_projection_core
package psp_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned MaxPower  = 16;
  localparam int unsigned TaylorTerms = 12;

  // fixed point constants
  localparam logic [30:0] FX_ONE    = 31'h4000_0000;  // 1.0 in Q1.30
  localparam logic [15:0] LN2_Q16   = 16'd45426;      // ln 2 in Q16.16
  localparam logic [31:0] LN2_RECIP = 32'd94548;      // floor(2^32 / LN2_Q16)
  localparam logic [21:0] T_SAT     = 22'h20_0000;    // 32.0 in Q16.16

  // item commands
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_STEEPNESS     = 2'd0;
  localparam logic [1:0] CFG_PENALTY_POWER = 2'd1;
  localparam logic [1:0] CFG_POINTS_IN_USE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SR_ADDR,
    ST_SR_CMP,
    ST_RD_LO,
    ST_RD_HI,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_U,
    ST_KDIV,
    ST_T_A,
    ST_T_B,
    ST_T_C,
    ST_T_D,
    ST_EXP,
    ST_DIV,
    ST_S,
    ST_POW_M,
    ST_POW_A,
    ST_Y_M,
    ST_Y_A,
    ST_G,
    ST_GM,
    ST_SL1,
    ST_SL2
  } psp_state_t;

  // floor(2^32 / n) for the taylor term divisor, n = 2..12 (n = 1 is bypassed)
  function automatic logic [31:0] recip_n(input logic [3:0] n);
    logic [31:0] r;
    begin
      case (n)
        4'd2:    r = 32'd2147483648;
        4'd3:    r = 32'd1431655765;
        4'd4:    r = 32'd1073741824;
        4'd5:    r = 32'd858993459;
        4'd6:    r = 32'd715827882;
        4'd7:    r = 32'd613566756;
        4'd8:    r = 32'd536870912;
        4'd9:    r = 32'd477218588;
        4'd10:   r = 32'd429496729;
        4'd11:   r = 32'd390451572;
        4'd12:   r = 32'd357913941;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/psp_mul.sv =====
// psp_mul: shared 33 x 32 unsigned multiplier with registered product
// depends on nothing beyond the package
module psp_mul import psp_pkg::*; (
  input  logic        clk,
  input  logic [32:0] op_a,
  input  logic [31:0] op_b,
  output logic [64:0] prod_r
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= 65'(op_a) * 65'(op_b);
  end

endmodule

// ===== rtl/core/piecewise_sigmoid_projection_core.sv =====
// piecewise_sigmoid_projection_core: top level, sequencer, knot store and datapath
// depends on psp_pkg and psp_mul
//
// Takes one item when start is high and busy is low. A load item writes one
// breakpoint pair in that same cycle and leaves the core free at once. A project
// item searches the knot table, then evaluates exp, a reciprocal and the power
// term on one shared multiplier with separate adders and comparators, one step per
// cycle. A project item keeps the core busy through the knot search, the division
// by ln 2, the twelve Taylor terms, the bit-serial reciprocal and the power steps.
// Its result shows for exactly one cycle on out_valid, in the same cycle that busy
// falls; the receiver cannot stall it. Knots are 16 slots of flip-flop store,
// undefined until loaded. The user must write registers through cfg_* only while
// the core is idle; the block does not enforce this. cfg_ready is always high.
module piecewise_sigmoid_projection_core import psp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [3:0]  in_point_index,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_value_x,
  // result channel
  output logic        out_valid,
  output logic signed [31:0] out_projected_y,
  output logic signed [31:0] out_slope,
  output logic [3:0]  out_segment,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  psp_state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] beta_r;
  logic [4:0]  power_r;
  logic [4:0]  points_r;
  logic [4:0]  n_c, p_c;

  // knot store
  logic [31:0] knot_x_mem [MaxPoints];
  logic [31:0] knot_y_mem [MaxPoints];
  logic [3:0]  rd_addr;
  logic signed [31:0] kx_rd_r, ky_rd_r;

  // datapath registers
  logic signed [31:0] x_r, x1_r, y1_r, mid_r;
  logic [4:0]  cnt_r;
  logic [3:0]  seg_r;
  logic [32:0] mag_r, ad_r;
  logic        neg_dy_r, neg_t_r;
  logic [21:0] m_r, rr_r;
  logic [5:0]  k_r;
  logic [30:0] term_r, a_r, q0_r, q_r, s_r, c_r, sp_r, nlo_r;
  logic signed [31:0] sum_r;
  logic [3:0]  tn_r;
  logic [31:0] den_r, rem_r;
  logic [20:0] gm_hi_r;
  logic [64:0] acc_r;
  logic        out_valid_r;
  logic signed [31:0] out_y_r, out_sl_r;
  logic [3:0]  out_seg_r;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod_r;

  psp_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // clamped register views
  always_comb begin
    n_c = points_r;
    if (points_r < 5'd2) n_c = 5'd2;
    if (points_r > 5'(MaxPoints)) n_c = 5'(MaxPoints);
    p_c = power_r;
    if (power_r < 5'd1) p_c = 5'd1;
    if (power_r > 5'(MaxPower)) p_c = 5'(MaxPower);
  end

  // combinational helpers for the step in hand
  logic        accept, is_less, seg_found;
  logic [4:0]  idx_raw;
  logic [4:0]  idx_cl;
  logic signed [32:0] sum_x, dy_w, d_w;
  logic [41:0] u_pre;
  logic [21:0] u_sat, k_rem;
  logic [30:0] q0_w, term_w, e_w, g_w;
  logic [30:0] rem_t;
  logic [31:0] den_w;
  logic [32:0] rem2;
  logic        div_ge;
  logic [30:0] s_w;
  logic [63:0] rnd64;
  logic [33:0] t_w;
  logic signed [34:0] y_w;
  logic [85:0] full_w, rnd86;
  logic [47:0] res_w, cap_w, sl_w;
  logic signed [31:0] sl_out;

  assign accept  = start && (state_r == ST_IDLE);
  assign is_less = $signed(x_r) < kx_rd_r;
  assign seg_found = is_less || (cnt_r == n_c - 5'd1);
  assign idx_raw = is_less ? cnt_r : n_c;

  always_comb begin
    idx_cl = idx_raw;
    if (idx_raw < 5'd1) idx_cl = 5'd1;
    if (idx_raw > n_c - 5'd1) idx_cl = n_c - 5'd1;
  end

  always_comb begin
    sum_x  = 33'(x1_r) + 33'(kx_rd_r);
    dy_w   = 33'(ky_rd_r) - 33'(y1_r);
    d_w    = 33'(x_r) - 33'(mid_r);
    u_pre  = prod_r[48:7];
    u_sat  = (u_pre > 42'(T_SAT)) ? T_SAT : u_pre[21:0];
    k_rem  = rr_r - prod_r[21:0];
    q0_w   = (tn_r == 4'd1) ? a_r : prod_r[62:32];
    rem_t  = a_r - prod_r[30:0];
    term_w = (rem_t >= 31'(tn_r)) ? q0_r + 31'd1 : q0_r;
    if (sum_r < 0 || k_r >= 6'd31) e_w = '0;
    else e_w = sum_r[30:0] >> k_r;
    den_w  = 32'(FX_ONE) + 32'(e_w);
    rem2   = {rem_r, nlo_r[cnt_r]};
    div_ge = rem2 >= {1'b0, den_r};
    s_w    = neg_t_r ? FX_ONE - q_r : q_r;
    rnd64  = prod_r[63:0] + 64'h2000_0000;
    t_w    = rnd64[63:30];
    g_w    = rnd64[60:30];
    y_w    = neg_dy_r ? 35'(y1_r) - 35'(t_w) : 35'(y1_r) + 35'(t_w);
    full_w = 86'(acc_r) + {prod_r[53:0], 32'd0};
    rnd86  = full_w + 86'h20_0000_0000;
    res_w  = rnd86[85:38];
    cap_w  = neg_dy_r ? 48'h8000_0000 : 48'h7FFF_FFFF;
    sl_w   = (res_w > cap_w) ? cap_w : res_w;
    sl_out = neg_dy_r ? 32'(48'd0 - sl_w) : sl_w[31:0];
  end

  // next state, read address and multiplier operands
  always_comb begin
    state_nxt = state_r;
    rd_addr   = cnt_r[3:0];
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE:    if (start && in_cmd == CMD_PROJECT) state_nxt = ST_SR_ADDR;
      ST_SR_ADDR: state_nxt = ST_SR_CMP;
      ST_SR_CMP:  state_nxt = seg_found ? ST_RD_LO : ST_SR_ADDR;
      ST_RD_LO: begin
        rd_addr   = seg_r - 4'd1;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        rd_addr   = seg_r;
        state_nxt = ST_D1;
      end
      ST_D1: begin
        mul_a     = 33'(beta_r);
        mul_b     = 32'(p_c);
        state_nxt = ST_D2;
      end
      ST_D2: state_nxt = ST_D3;
      ST_D3: begin
        mul_a     = ad_r;
        mul_b     = 32'(beta_r);
        state_nxt = ST_U;
      end
      ST_U: begin
        mul_a     = 33'(u_sat);
        mul_b     = LN2_RECIP;
        state_nxt = ST_KDIV;
      end
      ST_KDIV: begin
        if (cnt_r != 5'd0) begin
          mul_a = 33'(prod_r[37:32]);
          mul_b = 32'(LN2_Q16);
        end else begin
          state_nxt = ST_T_A;
        end
      end
      ST_T_A: begin
        mul_a     = 33'(term_r);
        mul_b     = 32'(rr_r[15:0]);
        state_nxt = ST_T_B;
      end
      ST_T_B: begin
        mul_a     = 33'(prod_r[46:16]);
        mul_b     = recip_n(tn_r);
        state_nxt = ST_T_C;
      end
      ST_T_C: begin
        mul_a     = 33'(q0_w);
        mul_b     = 32'(tn_r);
        state_nxt = ST_T_D;
      end
      ST_T_D:  state_nxt = (tn_r == 4'(TaylorTerms)) ? ST_EXP : ST_T_A;
      ST_EXP:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd0) state_nxt = ST_S;
      ST_S:    state_nxt = ST_POW_M;
      ST_POW_M: begin
        mul_a     = 33'(sp_r);
        mul_b     = 32'(s_r);
        state_nxt = ST_POW_A;
      end
      ST_POW_A: state_nxt = (cnt_r + 5'd1 == p_c) ? ST_Y_M : ST_POW_M;
      ST_Y_M: begin
        mul_a     = mag_r;
        mul_b     = 32'(sp_r);
        state_nxt = ST_Y_A;
      end
      ST_Y_A: begin
        mul_a     = 33'(sp_r);
        mul_b     = 32'(c_r);
        state_nxt = ST_G;
      end
      ST_G: begin
        mul_a     = 33'(g_w);
        mul_b     = 32'(m_r);
        state_nxt = ST_GM;
      end
      ST_GM: begin
        mul_a     = mag_r;
        mul_b     = prod_r[31:0];
        state_nxt = ST_SL1;
      end
      ST_SL1: begin
        mul_a     = mag_r;
        mul_b     = 32'(gm_hi_r);
        state_nxt = ST_SL2;
      end
      ST_SL2:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      beta_r      <= 16'd256;
      power_r     <= 5'd1;
      points_r    <= 5'd2;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_SL2);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_STEEPNESS:     beta_r   <= cfg_data;
          CFG_PENALTY_POWER: power_r  <= cfg_data[4:0];
          CFG_POINTS_IN_USE: points_r <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // knot store: written by load items, one registered read port
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD) begin
      knot_x_mem[in_point_index] <= in_point_x;
      knot_y_mem[in_point_index] <= in_point_y;
    end
    kx_rd_r <= knot_x_mem[rd_addr];
    ky_rd_r <= knot_y_mem[rd_addr];
  end

  // datapath steps
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r   <= in_value_x;
        cnt_r <= '0;
      end
      ST_SR_CMP: begin
        if (seg_found) seg_r <= idx_cl[3:0];
        else cnt_r <= cnt_r + 5'd1;
      end
      ST_RD_HI: begin
        x1_r <= kx_rd_r;
        y1_r <= ky_rd_r;
      end
      // midpoint and knot step in y
      ST_D1: begin
        mid_r    <= 32'(sum_x >>> 1);
        neg_dy_r <= dy_w < 0;
        mag_r    <= (dy_w < 0) ? 33'(-dy_w) : 33'(dy_w);
      end
      ST_D2: begin
        m_r     <= {prod_r[20:0], 1'b0};
        neg_t_r <= d_w < 0;
        ad_r    <= (d_w < 0) ? 33'(-d_w) : 33'(d_w);
      end
      // |t| in Q16.16, saturated
      ST_U: begin
        rr_r  <= u_sat;
        k_r   <= '0;
        cnt_r <= 5'd1;
      end
      // division by ln 2: reciprocal estimate, then remainder with one correction
      ST_KDIV: begin
        if (cnt_r != 5'd0) begin
          k_r <= prod_r[37:32];
        end else if (k_rem >= 22'(LN2_Q16)) begin
          rr_r <= k_rem - 22'(LN2_Q16);
          k_r  <= k_r + 6'd1;
        end else begin
          rr_r <= k_rem;
        end
        cnt_r  <= cnt_r - 5'd1;
        term_r <= FX_ONE;
        sum_r  <= 32'(FX_ONE);
        tn_r   <= 4'd1;
      end
      // taylor term: multiply by r, divide by 65536 n via reciprocal and fix-up
      ST_T_B: a_r  <= prod_r[46:16];
      ST_T_C: q0_r <= q0_w;
      ST_T_D: begin
        term_r <= term_w;
        if (tn_r[0]) sum_r <= sum_r - 32'(term_w);
        else sum_r <= sum_r + 32'(term_w);
        tn_r <= tn_r + 4'd1;
      end
      // 2^60 + den/2 over den, bit-serial
      ST_EXP: begin
        den_r <= den_w;
        nlo_r <= den_w[31:1];
        rem_r <= 32'h2000_0000;
        q_r   <= '0;
        cnt_r <= 5'd30;
      end
      ST_DIV: begin
        rem_r <= div_ge ? 32'(rem2 - {1'b0, den_r}) : rem2[31:0];
        q_r   <= {q_r[29:0], div_ge};
        cnt_r <= cnt_r - 5'd1;
      end
      ST_S: begin
        s_r   <= s_w;
        c_r   <= FX_ONE - s_w;
        sp_r  <= FX_ONE;
        cnt_r <= '0;
      end
      ST_POW_A: begin
        sp_r  <= rnd64[60:30];
        cnt_r <= cnt_r + 5'd1;
      end
      // projected value, saturated
      ST_Y_A: begin
        if (y_w > 35'sh0_7FFF_FFFF) out_y_r <= 32'h7FFF_FFFF;
        else if (y_w < -35'sh0_8000_0000) out_y_r <= 32'h8000_0000;
        else out_y_r <= y_w[31:0];
      end
      ST_GM:  gm_hi_r <= prod_r[52:32];
      ST_SL1: acc_r   <= prod_r;
      ST_SL2: begin
        out_sl_r  <= sl_out;
        out_seg_r <= seg_r;
      end
      default: ;
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_projected_y = out_y_r;
  assign out_slope       = out_sl_r;
  assign out_segment     = out_seg_r;

  // result strobe only follows the slope step
  a_out_after_sl2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_SL2))
    else $error("result strobe without a finished item");

  // a project item makes the core busy
  a_project_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_PROJECT) |=> busy)
    else $error("project item did not start the sequencer");

  // chosen segment lies within the table in use
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_LO) |-> (seg_r >= 4'd1 && 5'(seg_r) <= n_c - 5'd1))
    else $error("segment index out of range");

  // reciprocal remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not reduced");

endmodule
